[rtl/core/wfgdd_pkg.sv]
// ----------------------------------------------------------------------------
// wfgdd_pkg
// Shared types and codes for the wait-for graph deadlock detector.
// ----------------------------------------------------------------------------
package wfgdd_pkg;

  localparam int unsigned AgentW  = 3;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_CHECK = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RMW  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [MaskW-1:0]  abort_mask;
    logic [AgentW-1:0] victim;
    logic              victim_valid;
    logic              cycle_found;
  } result_t;

endpackage

[rtl/core/wfgdd_mem.sv]
// ----------------------------------------------------------------------------
// wfgdd_mem
// Wait-for matrix storage: one row per agent, one read and one write port,
// registered read data. Per-row valid bits make unwritten rows read as zero.
// ----------------------------------------------------------------------------
module wfgdd_mem #(
  parameter int unsigned AGENTS = 8,
  parameter int unsigned IDXW   = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IDXW-1:0]   rd_addr_i,
  output logic [AGENTS-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [IDXW-1:0]   wr_addr_i,
  input  logic [AGENTS-1:0] wr_data_i
);

  logic [AGENTS-1:0] mem_q [AGENTS];
  logic [AGENTS-1:0] row_vld_q;
  logic [AGENTS-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en_i) begin
      row_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= row_vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/wfgdd_ctrl.sv]
// ----------------------------------------------------------------------------
// wfgdd_ctrl
// Request sequencer: edge add (read-modify-write), row clear, and the
// iterative peeling search for a cycle with victim selection.
// ----------------------------------------------------------------------------
module wfgdd_ctrl #(
  parameter int unsigned AGENTS = 8,
  parameter int unsigned IDXW   = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  logic [1:0]              req_func_i,
  input  logic [wfgdd_pkg::AgentW-1:0] req_waiter_i,
  input  logic [wfgdd_pkg::AgentW-1:0] req_owner_i,
  input  logic                    out_free_i,
  output logic                    res_load_o,
  output wfgdd_pkg::result_t      res_o,
  output logic                    rd_en_o,
  output logic [IDXW-1:0]         rd_addr_o,
  input  logic [AGENTS-1:0]       rd_data_i,
  output logic                    wr_en_o,
  output logic [IDXW-1:0]         wr_addr_o,
  output logic [AGENTS-1:0]       wr_data_o
);
  import wfgdd_pkg::*;

  localparam logic [IDXW-1:0]   LastIdx = IDXW'(AGENTS - 1);
  localparam logic [AGENTS-1:0] OneBit  = {{(AGENTS-1){1'b0}}, 1'b1};

  state_e            state_q, state_d;
  logic [IDXW-1:0]   waiter_q, waiter_d;
  logic [AgentW-1:0] owner_q, owner_d;
  logic              issue_q, issue_d;
  logic [IDXW-1:0]   idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [IDXW-1:0]   pidx_q, pidx_d;
  logic [AGENTS-1:0] alive_q, alive_d;
  logic              changed_q, changed_d;
  logic              first_q, first_d;
  logic              edge_q, edge_d;
  logic [IDXW-1:0]   vict_q, vict_d;
  logic [AGENTS-1:0] flags_q, flags_d;
  logic              found_q, found_d;
  logic              vvalid_q, vvalid_d;
  logic [IDXW-1:0]   victim_q, victim_d;

  logic              waiter_ok;
  logic              owner_ok;
  logic              drop;
  logic              chg;
  logic              cyc;
  logic [AGENTS-1:0] alive_nx;

  assign waiter_ok = 32'(req_waiter_i) < 32'(AGENTS);
  assign owner_ok  = 32'(req_owner_i) < 32'(AGENTS);

  always_comb begin
    state_d   = state_q;
    waiter_d  = waiter_q;
    owner_d   = owner_q;
    issue_d   = issue_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    alive_d   = alive_q;
    changed_d = changed_q;
    first_d   = first_q;
    edge_d    = edge_q;
    vict_d    = vict_q;
    flags_d   = flags_q;
    found_d   = found_q;
    vvalid_d  = vvalid_q;
    victim_d  = victim_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q;
    wr_en_o   = 1'b0;
    wr_addr_o = waiter_q;
    wr_data_o = '0;
    res_load_o = 1'b0;
    drop      = 1'b0;
    chg       = 1'b0;
    cyc       = 1'b0;
    alive_nx  = alive_q;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          waiter_d = IDXW'(req_waiter_i);
          owner_d  = req_owner_i;
          found_d  = 1'b0;
          vvalid_d = 1'b0;
          victim_d = '0;
          state_d  = ST_DONE;
          case (func_e'(req_func_i))
            FUNC_ADD: begin
              if (waiter_ok && owner_ok) begin
                rd_en_o   = 1'b1;
                rd_addr_o = IDXW'(req_waiter_i);
                state_d   = ST_RMW;
              end
            end
            FUNC_CLEAR: begin
              if (waiter_ok) begin
                wr_en_o   = 1'b1;
                wr_addr_o = IDXW'(req_waiter_i);
              end
            end
            FUNC_CHECK: begin
              issue_d   = 1'b1;
              idx_d     = '0;
              alive_d   = '1;
              changed_d = 1'b0;
              first_d   = 1'b1;
              edge_d    = 1'b0;
              vict_d    = '0;
              state_d   = ST_SCAN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_RMW: begin
        wr_en_o   = 1'b1;
        wr_data_o = rd_data_i | (OneBit << owner_q);
        state_d   = ST_DONE;
      end
      ST_SCAN: begin
        rd_en_o = issue_q;
        if (issue_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (idx_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (pend_q) begin
          drop = alive_q[pidx_q] && ((rd_data_i & alive_q) == '0);
          if (drop) begin
            alive_nx = alive_q & ~(OneBit << pidx_q);
          end
          alive_d = alive_nx;
          chg     = changed_q | drop;
          if (first_q && (rd_data_i != '0)) begin
            edge_d = 1'b1;
            vict_d = pidx_q;
          end
          changed_d = chg;
          if (pidx_q == LastIdx) begin
            if (chg) begin
              issue_d   = 1'b1;
              idx_d     = '0;
              changed_d = 1'b0;
              first_d   = 1'b0;
            end else begin
              cyc      = (alive_nx != '0) && edge_d;
              found_d  = alive_nx != '0;
              vvalid_d = cyc;
              victim_d = cyc ? vict_d : '0;
              if (cyc) begin
                flags_d = flags_q | (OneBit << vict_d);
              end
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issue_q   <= 1'b0;
      pend_q    <= 1'b0;
      flags_q   <= '0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      pend_q    <= pend_d;
      flags_q   <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    waiter_q  <= waiter_d;
    owner_q   <= owner_d;
    idx_q     <= idx_d;
    pidx_q    <= pidx_d;
    alive_q   <= alive_d;
    changed_q <= changed_d;
    first_q   <= first_d;
    edge_q    <= edge_d;
    vict_q    <= vict_d;
    found_q   <= found_d;
    vvalid_q  <= vvalid_d;
    victim_q  <= victim_d;
  end

  assign req_ready_o        = (state_q == ST_IDLE);
  assign res_o.cycle_found  = found_q;
  assign res_o.victim_valid = vvalid_q;
  assign res_o.victim       = AgentW'(32'(victim_q));
  assign res_o.abort_mask   = MaskW'(32'(flags_q));

endmodule

[rtl/core/wait_for_graph_deadlock_detector_unit.sv]
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector_unit
// Wait-for graph deadlock detector over AGENTS agents with sticky aborts.
// ----------------------------------------------------------------------------
// Each request returns one response. An add reads the row, writes it back
// with the owner bit set and responds; a clear writes the row to zero and
// responds; a check walks the wait-for matrix row by row through its single
// read port, pass after pass, peeling agents that wait on no surviving
// agent, and at most AGENTS + 1 passes run.
// One request is in flight at a time; a new request is taken while the
// previous response still sits in the output register. The matrix reads as
// all zero after reset with no clearing pass.
module wait_for_graph_deadlock_detector_unit #(
  parameter int unsigned AGENTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // waiter[2:0], owner_agent[5:3]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // cycle_found, victim_valid, victim[2:0],
                                     // abort_mask[7:0]
);
  import wfgdd_pkg::*;

  localparam int unsigned IDXW = $clog2(AGENTS);

  logic              rd_en;
  logic [IDXW-1:0]   rd_addr;
  logic [AGENTS-1:0] rd_data;
  logic              wr_en;
  logic [IDXW-1:0]   wr_addr;
  logic [AGENTS-1:0] wr_data;
  logic              res_load;
  result_t           res;
  result_t           out_q;
  logic              out_vld_q;
  logic              out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  wfgdd_ctrl #(
    .AGENTS (AGENTS),
    .IDXW   (IDXW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_func_i   (s_axis_tuser),
    .req_waiter_i (s_axis_tdata[2:0]),
    .req_owner_i  (s_axis_tdata[5:3]),
    .out_free_i   (out_free),
    .res_load_o   (res_load),
    .res_o        (res),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  wfgdd_mem #(
    .AGENTS (AGENTS),
    .IDXW   (IDXW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q.abort_mask, out_q.victim,
                          out_q.victim_valid, out_q.cycle_found};

endmodule

[rtl/core/wfgdd_checker.sv]
// ----------------------------------------------------------------------------
// wfgdd_checker
// Port-level checks for the deadlock detector, bound to the top level.
// ----------------------------------------------------------------------------
module wfgdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic [7:0] last_mask_q;
  logic [7:0] mask;
  logic [2:0] victim;

  assign mask   = m_axis_tdata[12:5];
  assign victim = m_axis_tdata[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_mask_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_mask_q <= mask;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("response changed while stalled");

  a_flags_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((mask & last_mask_q) == last_mask_q))
    else $error("abort flag cleared");

  a_victim_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1] == m_axis_tdata[0])
                      && (m_axis_tdata[1] || (victim == 3'd0)))
    else $error("victim fields inconsistent");

  a_victim_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> mask[victim])
    else $error("victim abort flag not set");

endmodule

bind wait_for_graph_deadlock_detector_unit wfgdd_checker u_wfgdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[test/wait_for_graph_deadlock_detector_unit_test.sv]
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector_unit_test
// Self-checking bench for the wait-for graph deadlock detector. Requests go in
// on the slave stream and are predicted as they are accepted; each response on
// the master stream is compared field by field with the oldest prediction.
// Directed cases come first, then random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wfgdd_pkg::*;

  localparam int unsigned Agents     = 8;
  localparam logic [1:0]  FuncUnused = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // waiter[2:0], owner_agent[5:3]
  logic [1:0]  s_axis_tuser  = '0;  // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // cycle_found, victim_valid, victim[2:0],
                                    // abort_mask[7:0]

  int idle_pct       = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;

  // shadow of the block's state
  logic [Agents-1:0] wait_rows [Agents];
  logic [Agents-1:0] abort_flags;
  result_t           pending_results [$];

  wait_for_graph_deadlock_detector_unit #(
    .AGENTS(Agents)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // peel agents that wait on no surviving agent; survivors mean a cycle
  function automatic logic graph_deadlocked();
    logic [Agents-1:0] alive;
    logic              changed;
    alive   = '1;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < Agents; i++) begin
        if (alive[i] && (wait_rows[i] & alive) == '0) begin
          alive[i] = 1'b0;
          changed  = 1'b1;
        end
      end
    end
    return alive != '0;
  endfunction

  function automatic result_t predict_response(logic [1:0] func, logic [2:0] waiter,
                                               logic [2:0] owner);
    result_t res;
    res = '0;
    case (func)
      FUNC_ADD: begin
        wait_rows[waiter][owner] = 1'b1;
      end
      FUNC_CLEAR: begin
        wait_rows[waiter] = '0;
      end
      FUNC_CHECK: begin
        if (graph_deadlocked()) begin
          res.cycle_found = 1'b1;
          for (int i = Agents - 1; i >= 0; i--) begin
            if (wait_rows[i] != '0 && !res.victim_valid) begin
              res.victim_valid = 1'b1;
              res.victim       = 3'(i);
              abort_flags[i]   = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.abort_mask = abort_flags;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    end
  endtask

  task automatic send_request(logic [1:0] func, logic [2:0] waiter, logic [2:0] owner);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, owner, waiter};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_response(func, waiter, owner));
  endtask

  initial begin : response_monitor
    result_t got;
    result_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (pending_results.size() == 0) begin
          report_mismatch("response with no request pending", int'(got), 0);
        end else begin
          want = pending_results.pop_front();
          if (got.cycle_found != want.cycle_found)
            report_mismatch("cycle_found", int'(got.cycle_found),
                            int'(want.cycle_found));
          if (got.victim_valid != want.victim_valid)
            report_mismatch("victim_valid", int'(got.victim_valid),
                            int'(want.victim_valid));
          if (got.victim != want.victim)
            report_mismatch("victim", int'(got.victim), int'(want.victim));
          if (got.abort_mask != want.abort_mask)
            report_mismatch("abort_mask", int'(got.abort_mask),
                            int'(want.abort_mask));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(FUNC_CHECK, 3'd0, 3'd0);   // empty graph
    send_request(FUNC_ADD,   3'd0, 3'd0);   // self edge
    send_request(FUNC_CHECK, 3'd0, 3'd0);
    send_request(FUNC_CLEAR, 3'd0, 3'd0);
    send_request(FUNC_ADD,   3'd7, 3'd7);
    send_request(FUNC_CHECK, 3'd7, 3'd7);
    send_request(FUNC_CLEAR, 3'd7, 3'd7);
    send_request(FUNC_ADD,   3'd0, 3'd7);
    send_request(FUNC_ADD,   3'd7, 3'd0);
    send_request(FUNC_CHECK, 3'd0, 3'd0);   // victim already flagged
    send_request(FUNC_CLEAR, 3'd7, 3'd0);
    send_request(FUNC_CHECK, 3'd0, 3'd0);   // chain left, no cycle
    send_request(FUNC_ADD,   3'd1, 3'd2);
    send_request(FUNC_ADD,   3'd2, 3'd3);
    send_request(FUNC_ADD,   3'd3, 3'd1);
    send_request(FUNC_ADD,   3'd5, 3'd6);   // acyclic edge outranks the cycle
    send_request(FUNC_CHECK, 3'd0, 3'd0);
    send_request(FuncUnused, 3'd7, 3'd7);   // unused code must not touch state
    send_request(FuncUnused, 3'd0, 3'd0);
    send_request(FUNC_CLEAR, 3'd5, 3'd0);
    send_request(FUNC_CLEAR, 3'd2, 3'd0);
    send_request(FUNC_CHECK, 3'd0, 3'd0);
    send_request(FUNC_CLEAR, 3'd0, 3'd0);
  endtask

  task automatic run_random_phase(int idle, int stall, int count);
    logic [1:0] func;
    logic [2:0] waiter;
    logic [2:0] owner;
    int         span;
    int         pick;
    idle_pct  = idle;
    stall_pct = stall;
    span      = 7;
    repeat (count) begin
      // narrow the agent range now and then so low victims show up
      if ($urandom_range(31) == 0) span = (1 << $urandom_range(1, 3)) - 1;
      pick   = $urandom_range(99);
      func   = (pick < 45) ? FUNC_ADD : (pick < 70) ? FUNC_CLEAR :
               (pick < 95) ? FUNC_CHECK : FuncUnused;
      waiter = 3'($urandom_range(span));
      owner  = 3'($urandom_range(span));
      if ($urandom_range(9) == 0) owner = 3'($urandom_range(7));
      send_request(func, waiter, owner);
    end
  endtask

  task automatic test_streaming_no_idle();
    run_random_phase(0, 0, 240);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(73, 0, 235);
  endtask

  task automatic test_receiver_stalls();
    run_random_phase(0, 73, 235);
  endtask

  task automatic test_both_sides_idle();
    run_random_phase(16, 16, 240);
  endtask

  initial begin : regression
    for (int i = 0; i < Agents; i++) wait_rows[i] = '0;
    abort_flags = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
